[rtl/ncst_pkg.sv]
`timescale 1ns / 1ps
package ncst_pkg;

   localparam int Semaphores = 32;
   localparam int QueueSlots = 16;
   localparam int NameBytes  = 16;
   localparam int SlotW      = $clog2(Semaphores);
   localparam int QueueW     = $clog2(QueueSlots);
   localparam int EntryW     = SlotW + QueueW;

   typedef enum logic [1:0] {
      CMD_OPEN   = 2'd0,
      CMD_WAIT   = 2'd1,
      CMD_POST   = 2'd2,
      CMD_UNLINK = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TOO_LONG   = 3'd1,
      ST_TABLE_FULL = 3'd2,
      ST_NOT_FOUND  = 3'd3,
      ST_QUEUE_FULL = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [4:0]  sem_index;
      logic [63:0] name_low;
      logic [63:0] name_high;
      logic [14:0] initial_value;
      logic [5:0]  task_id;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] slot;
      logic       block_caller;
      logic       wake_valid;
      logic [5:0] wake_task;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, canonicalise name
      logic scan_clr;   // reset scan pointer
      logic scan_step;  // compare slot at pointer, advance
      logic rd_slot;    // not used by the datapath
      logic do_open;
      logic do_unlink;
      logic do_wait;
      logic do_post;
      logic finish_post; // latch queue read data
   } cmd_bus_type;

   // datapath to controller
   typedef struct packed {
      logic too_long;
      logic scan_done;
      logic hit;
   } sts_bus_type;

endpackage

[rtl/ncst_ram.sv]
`timescale 1ns / 1ps
module ncst_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/ncst_datapath.sv]
`timescale 1ns / 1ps
module ncst_datapath
   import ncst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_in,
   input  cmd_bus_type cmd,
   output sts_bus_type sts,
   output rsp_type     result
);
   logic [Semaphores-1:0] in_use_ff;
   logic [63:0]           name_lo_mem [Semaphores];
   logic [63:0]           name_hi_mem [Semaphores];
   logic [15:0]           count_mem   [Semaphores];
   logic [QueueW-1:0]     head_mem    [Semaphores];
   logic [QueueW-1:0]     tail_mem    [Semaphores];

   req_type           req_ff;
   logic [63:0]       lo_ff, hi_ff;
   logic              too_long_ff;
   logic [SlotW:0]    ptr_ff;
   logic              hit_ff, free_ff;
   logic [SlotW-1:0]  hit_slot_ff, free_slot_ff;
   rsp_type           result_ff;

   logic [63:0]       lo_in, hi_in;
   logic              too_long_in;
   rsp_type           result_in;
   logic [SlotW-1:0]  ptr;
   logic [SlotW-1:0]  idx;
   logic              idx_ok;
   logic [15:0]       cnt, cnt_dec, cnt_inc;
   logic [QueueW-1:0] head, tail, tail_nx;
   logic              q_wr;
   logic [EntryW-1:0] q_waddr, q_raddr;
   logic [5:0]        q_rdata;

   // canonicalise: bytes after the first zero become zero
   always_comb begin
      logic seen;
      logic [7:0] b;
      seen = 1'b0;
      lo_in = '0;
      hi_in = '0;
      for (int i = 0; i < 16; i++) begin
         b = (i < 8) ? req_in.name_low[8*(i%8) +: 8] : req_in.name_high[8*(i%8) +: 8];
         if (i < NameBytes && b == 8'd0) seen = 1'b1;
         if (!seen) begin
            if (i < 8) lo_in[8*(i%8) +: 8] = b;
            else       hi_in[8*(i%8) +: 8] = b;
         end
      end
      too_long_in = !seen;
   end

   assign ptr     = ptr_ff[SlotW-1:0];
   assign idx     = req_ff.sem_index[SlotW-1:0];
   assign idx_ok  = (32'(req_ff.sem_index) < Semaphores) && in_use_ff[idx];
   assign cnt     = count_mem[idx];
   assign head    = head_mem[idx];
   assign tail    = tail_mem[idx];
   assign tail_nx = tail + 1'b1;
   assign cnt_dec = (cnt != 16'h8000) ? cnt - 16'd1 : cnt;
   assign cnt_inc = (cnt != 16'h7fff) ? cnt + 16'd1 : cnt;
   assign q_wr    = cmd.do_wait && idx_ok && cnt_dec[15] && (tail_nx != head);
   assign q_waddr = {idx, tail};
   assign q_raddr = {idx, head};

   ncst_ram #(.Width(6), .Depth(Semaphores * QueueSlots)) u_queue (
      .clock   (clock),
      .wr_en   (q_wr),
      .wr_addr (q_waddr),
      .wr_data (req_ff.task_id),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   always_comb begin
      result_in = result_ff;
      if (cmd.do_open) begin
         result_in = '0;
         if (too_long_ff) result_in.status = ST_TOO_LONG;
         else if (hit_ff) result_in.slot = 5'(hit_slot_ff);
         else if (free_ff) result_in.slot = 5'(free_slot_ff);
         else result_in.status = ST_TABLE_FULL;
      end
      if (cmd.do_unlink) begin
         result_in = '0;
         if (too_long_ff) result_in.status = ST_TOO_LONG;
         else if (hit_ff) result_in.slot = 5'(hit_slot_ff);
         else result_in.status = ST_NOT_FOUND;
      end
      if (cmd.do_wait) begin
         result_in      = '0;
         result_in.slot = req_ff.sem_index;
         if (!idx_ok) result_in.status = ST_NOT_FOUND;
         else if (cnt_dec[15]) begin
            result_in.block_caller = 1'b1;
            if (tail_nx == head) result_in.status = ST_QUEUE_FULL;
         end
      end
      if (cmd.do_post) begin
         result_in      = '0;
         result_in.slot = req_ff.sem_index;
         if (!idx_ok) result_in.status = ST_NOT_FOUND;
         else if ((cnt_inc[15] || cnt_inc == 16'd0) && head != tail)
            result_in.wake_valid = 1'b1;
      end
      // queue data was addressed by the old head during do_post
      if (cmd.finish_post && result_ff.wake_valid) result_in.wake_task = q_rdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_in;
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         too_long_ff <= too_long_in;
      end
      if (cmd.scan_clr) begin
         ptr_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         ptr_ff <= ptr_ff + 1'b1;
         if (in_use_ff[ptr] && name_lo_mem[ptr] == lo_ff && name_hi_mem[ptr] == hi_ff
             && !hit_ff) begin
            hit_ff      <= 1'b1;
            hit_slot_ff <= ptr;
         end
         if (!in_use_ff[ptr] && !free_ff) begin
            free_ff      <= 1'b1;
            free_slot_ff <= ptr;
         end
      end
      result_ff <= result_in;
      if (cmd.do_open && !too_long_ff && !hit_ff && free_ff) begin
         name_lo_mem[free_slot_ff] <= lo_ff;
         name_hi_mem[free_slot_ff] <= hi_ff;
         count_mem[free_slot_ff]   <= 16'(req_ff.initial_value);
         head_mem[free_slot_ff]    <= '0;
         tail_mem[free_slot_ff]    <= '0;
      end
      if (cmd.do_unlink && !too_long_ff && hit_ff) begin
         name_lo_mem[hit_slot_ff] <= '0;
         name_hi_mem[hit_slot_ff] <= '0;
         count_mem[hit_slot_ff]   <= '0;
      end
      if (cmd.do_wait && idx_ok) begin
         count_mem[idx] <= cnt_dec;
         if (cnt_dec[15] && tail_nx != head) tail_mem[idx] <= tail_nx;
      end
      if (cmd.do_post && idx_ok) begin
         count_mem[idx] <= cnt_inc;
         if ((cnt_inc[15] || cnt_inc == 16'd0) && head != tail)
            head_mem[idx] <= head + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         if (cmd.do_open && !too_long_ff && !hit_ff && free_ff)
            in_use_ff[free_slot_ff] <= 1'b1;
         if (cmd.do_unlink && !too_long_ff && hit_ff)
            in_use_ff[hit_slot_ff] <= 1'b0;
      end
   end

   assign sts.too_long  = too_long_ff;
   assign sts.scan_done = ptr_ff[SlotW];
   assign sts.hit       = hit_ff;
   assign result        = result_ff;
endmodule

[rtl/ncst_ctrl.sv]
`timescale 1ns / 1ps
module ncst_ctrl
   import ncst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_command,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  sts_bus_type sts,
   output cmd_bus_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_EXEC, S_POSTRD, S_RESP
   } state_type;

   state_type state_ff, state_in;
   cmd_type   op_ff;
   logic      rsp_valid_ff, rsp_valid_in;

   // a new item may enter while the last result waits, if the result goes this cycle
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: if (req_valid && !req_stall) begin
            cmd.load     = 1'b1;
            cmd.scan_clr = 1'b1;
            if (cmd_type'(req_command) == CMD_OPEN || cmd_type'(req_command) == CMD_UNLINK)
               state_in = S_SCAN;
            else state_in = S_EXEC;
         end
         S_SCAN: begin
            if (sts.scan_done || sts.too_long) state_in = S_EXEC;
            else cmd.scan_step = 1'b1;
         end
         S_EXEC: begin
            unique case (op_ff)
               CMD_OPEN:   cmd.do_open   = 1'b1;
               CMD_UNLINK: cmd.do_unlink = 1'b1;
               CMD_WAIT:   cmd.do_wait   = 1'b1;
               CMD_POST:   cmd.do_post   = 1'b1;
            endcase
            if (op_ff == CMD_POST) state_in = S_POSTRD;
            else begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         S_POSTRD: begin
            cmd.finish_post = 1'b1;
            state_in        = S_IDLE;
            rsp_valid_in    = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         op_ff        <= CMD_OPEN;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load) op_ff <= cmd_type'(req_command);
      end
   end
endmodule

[rtl/named_counting_semaphore_table_core.sv]
`timescale 1ns / 1ps
// channel   direction  payload    handshake
// req       in         req_type   req_valid / req_stall
// rsp       out        rsp_type   rsp_valid / rsp_stall
// open and unlink: a scan of all 32 slots, one per cycle, then decide and update
// a name too long skips the scan
// post adds a state, S_POSTRD, for the registered read of the queue memory
// one item at a time; a new item enters as the previous result leaves
// reset clears slot occupancy and the controller; queue memory is not cleared
module named_counting_semaphore_table_core
   import ncst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   cmd_bus_type cmd;
   sts_bus_type sts;

   ncst_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   ncst_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_in (req_data),
      .cmd    (cmd),
      .sts    (sts),
      .result (rsp_data)
   );
endmodule

[rtl/ncst_checker.sv]
`timescale 1ns / 1ps
module ncst_checker
   import ncst_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid && req_stall)
      else $error("item overlap");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_QUEUE_FULL)
      else $error("bad status");

   a_wake_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.wake_valid |-> rsp_data.status == ST_OK && !rsp_data.block_caller)
      else $error("wake with error");
endmodule

bind named_counting_semaphore_table_core ncst_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   import ncst_pkg::*;

   localparam int CycleLimit = 2000000;
   localparam int HoldCycles = 200;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   named_counting_semaphore_table_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // semaphore table mirror
   logic        sem_used [Semaphores];
   logic [63:0] sem_lo [Semaphores];
   logic [63:0] sem_hi [Semaphores];
   int          mirror_count [Semaphores];
   int          q_head [Semaphores];
   int          q_tail [Semaphores];
   logic [5:0]  q_task [Semaphores][QueueSlots];

   rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      rsp_seen = 0;
   int      items_sent = 0;
   int      cycles = 0;
   int      hold_cycles = 0;
   bit      hold_off = 0;
   bit      stall_on = 1;

   // the ten names used most, so opens and unlinks keep hitting
   logic [63:0] pool_lo [10];

   function automatic rsp_type predict_semaphore(req_type r);
      rsp_type     o;
      logic [7:0]  b [16];
      logic [63:0] lo, hi;
      int          stop, s, t, nt;
      o = '0;
      stop = 16;
      for (int i = 0; i < 16; i++)
         b[i] = (i < 8) ? r.name_low[8*i +: 8] : r.name_high[8*(i-8) +: 8];
      for (int i = NameBytes - 1; i >= 0; i--)
         if (b[i] == 8'd0) stop = i;
      lo = '0;
      hi = '0;
      for (int i = 0; i < 16; i++)
         if (i < stop) begin
            if (i < 8) lo[8*i +: 8] = b[i];
            else hi[8*(i-8) +: 8] = b[i];
         end
      s = -1;
      if (r.command == CMD_OPEN || r.command == CMD_UNLINK) begin
         for (int i = Semaphores - 1; i >= 0; i--)
            if (sem_used[i] && sem_lo[i] == lo && sem_hi[i] == hi) s = i;
         if (stop == 16) begin
            o.status = ST_TOO_LONG;
         end else if (r.command == CMD_OPEN) begin
            if (s < 0) begin
               for (int i = Semaphores - 1; i >= 0; i--)
                  if (!sem_used[i]) s = i;
               if (s >= 0) begin
                  sem_used[s] = 1;
                  sem_lo[s] = lo;
                  sem_hi[s] = hi;
                  mirror_count[s] = int'(r.initial_value);
                  q_head[s] = 0;
                  q_tail[s] = 0;
               end
            end
            if (s < 0) o.status = ST_TABLE_FULL;
            else o.slot = 5'(s);
         end else if (s < 0) begin
            o.status = ST_NOT_FOUND;
         end else begin
            sem_used[s] = 0;
            sem_lo[s] = '0;
            sem_hi[s] = '0;
            mirror_count[s] = 0;
            o.slot = 5'(s);
         end
      end else begin
         s = int'(r.sem_index);
         o.slot = r.sem_index;
         if (!sem_used[s]) begin
            o.status = ST_NOT_FOUND;
         end else if (r.command == CMD_WAIT) begin
            if (mirror_count[s] > -32768) mirror_count[s]--;
            if (mirror_count[s] < 0) begin
               t = q_tail[s];
               nt = (t + 1) % QueueSlots;
               o.block_caller = 1;
               if (nt == q_head[s]) begin
                  o.status = ST_QUEUE_FULL;
               end else begin
                  q_task[s][t] = r.task_id;
                  q_tail[s] = nt;
               end
            end
         end else begin
            if (mirror_count[s] < 32767) mirror_count[s]++;
            if (mirror_count[s] <= 0 && q_head[s] != q_tail[s]) begin
               o.wake_valid = 1;
               o.wake_task = q_task[s][q_head[s]];
               q_head[s] = (q_head[s] + 1) % QueueSlots;
            end
         end
      end
      return o;
   endfunction

   task automatic send_item(req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      expected_rsps.push_back(predict_semaphore(r));
      items_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // bursts with random gaps; valid only lowered for a gap
   task automatic pace();
      if ($urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   function automatic req_type make_name_req(cmd_type c, logic [63:0] lo, logic [63:0] hi);
      req_type r;
      r = '0;
      r.command = c;
      r.name_low = lo;
      r.name_high = hi;
      r.initial_value = 15'($urandom);
      r.sem_index = 5'($urandom);
      r.task_id = 6'($urandom);
      return r;
   endfunction

   function automatic req_type make_slot_req(cmd_type c, int s);
      req_type r;
      r = '0;
      r.command = c;
      r.sem_index = 5'(s);
      r.task_id = 6'($urandom);
      r.initial_value = 15'($urandom);
      r.name_low = {$urandom, $urandom};
      r.name_high = {$urandom, $urandom};
      return r;
   endfunction

   task automatic test_name_forms();
      send_item(make_name_req(CMD_OPEN, 64'h0, 64'h0));
      send_item(make_name_req(CMD_OPEN, 64'h0, 64'h0));
      send_item(make_name_req(CMD_OPEN, '1, '1));
      send_item(make_name_req(CMD_OPEN, '1, 64'h00FF_FFFF_FFFF_FFFF));
      send_item(make_name_req(CMD_OPEN, 64'h0000_0000_0000_4241, '1));
      send_item(make_name_req(CMD_OPEN, 64'h4241, 64'h0));
      send_item(make_name_req(CMD_UNLINK, '1, '1));
      send_item(make_name_req(CMD_UNLINK, 64'h1234, 64'h0));
      send_item(make_name_req(CMD_UNLINK, 64'h4241, 64'h0));
      send_item(make_name_req(CMD_UNLINK, '1, 64'h00FF_FFFF_FFFF_FFFF));
      go_idle();
   endtask

   task automatic test_wait_post();
      req_type r;
      r = make_name_req(CMD_OPEN, 64'h77, 64'h0);
      r.initial_value = 15'd1;
      send_item(r);
      go_idle();
      // fill the queue past its depth, then drain beyond empty
      for (int i = 0; i < QueueSlots + 2; i++) send_item(make_slot_req(CMD_WAIT, 1));
      for (int i = 0; i < QueueSlots + 4; i++) send_item(make_slot_req(CMD_POST, 1));
      send_item(make_slot_req(CMD_WAIT, 31));
      send_item(make_slot_req(CMD_POST, 30));
      r = make_name_req(CMD_OPEN, 64'h78, 64'h0);
      r.initial_value = 15'h7FFF;
      send_item(r);
      send_item(make_slot_req(CMD_POST, 2));
      go_idle();
   endtask

   task automatic test_saturation();
      int s;
      s = 2;
      for (int i = 0; i < 3; i++) send_item(make_slot_req(CMD_POST, s));
      go_idle();
   endtask

   task automatic test_table_full();
      for (int i = 0; i < Semaphores + 2; i++)
         send_item(make_name_req(CMD_OPEN, 64'h5000 + 64'(i), 64'h0));
      for (int i = 0; i < Semaphores; i++)
         send_item(make_name_req(CMD_UNLINK, 64'h5000 + 64'(i), 64'h0));
      send_item(make_name_req(CMD_UNLINK, 64'h77, 64'h0));
      send_item(make_name_req(CMD_UNLINK, 64'h78, 64'h0));
      go_idle();
   endtask

   task automatic test_random(int n);
      req_type r;
      int      k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 15) begin
            r = make_name_req(CMD_OPEN, pool_lo[$urandom_range(0, 9)], 64'h0);
            if ($urandom_range(0, 9) == 0) r.initial_value = 15'h7FFF;
            else r.initial_value = 15'($urandom_range(0, 3));
         end else if (k < 22) begin
            r = make_name_req(CMD_UNLINK, pool_lo[$urandom_range(0, 9)], 64'h0);
         end else if (k < 26) begin
            r = make_name_req($urandom_range(0, 1) ? CMD_OPEN : CMD_UNLINK,
                              {$urandom, $urandom}, {$urandom, $urandom});
         end else if (k < 62) begin
            r = make_slot_req(CMD_WAIT, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 9));
         end else begin
            r = make_slot_req(CMD_POST, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 9));
         end
         send_item(r);
         pace();
      end
      go_idle();
   endtask

   task automatic test_back_pressure();
      hold_off = 1;
      for (int i = 0; i < 8; i++) send_item(make_slot_req(CMD_WAIT, $urandom_range(0, 9)));
      go_idle();
   endtask

   // receiver: stalls in runs of its own, or a long counted hold-off
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
         if (hold_cycles >= HoldCycles - 1) begin
            hold_off    <= 0;
            hold_cycles <= 0;
         end else begin
            hold_cycles <= hold_cycles + 1;
         end
      end else if (!stall_on) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= ~rsp_stall;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles % 20000 == 0) stall_on <= ~stall_on;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %p", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("item %0d: expected %p, got %p", rsp_seen, want, rsp_data);
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < Semaphores; i++) begin
         sem_used[i] = 0;
         sem_lo[i] = '0;
         sem_hi[i] = '0;
         mirror_count[i] = 0;
         q_head[i] = 0;
         q_tail[i] = 0;
      end
      for (int i = 0; i < 10; i++) pool_lo[i] = 64'h6100 + 64'(i);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_name_forms();
      test_wait_post();
      test_saturation();
      test_table_full();
      test_back_pressure();
      test_random(1200);
      repeat (50) @(posedge clock);
      $display("sent %0d items, checked %0d results: names, queues, table full, stalls",
               items_sent, rsp_seen);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d left over", mismatches, expected_rsps.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
